### hdl/tcir_pkg.sv
package tcir_pkg;

  localparam int MAX_GLYPH_ROWS     = 16;
  localparam int DOUBLE_WIDTH_LIMIT = 40;
  localparam int MAX_GLYPH_WIDTH    = 8;
  localparam int FONT_DEPTH         = 4096;
  localparam int FONT_AW            = 12;
  localparam int ADDR_W             = 21;
  localparam int ROW_W              = $clog2(MAX_GLYPH_ROWS);
  localparam int HEIGHT_W           = $clog2(MAX_GLYPH_ROWS + 1);
  localparam int PIX_MAX            = 16;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  localparam logic [2:0] REG_TEXT_COLUMNS  = 3'd0;
  localparam logic [2:0] REG_ROW_PITCH     = 3'd1;
  localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd2;
  localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_BLINK_DISABLE = 3'd4;
  localparam logic [2:0] REG_BLINK_PHASE   = 3'd5;
  localparam logic [2:0] REG_ORIGIN_COLUMN = 3'd6;
  localparam logic [2:0] REG_ORIGIN_ROW    = 3'd7;

  typedef struct packed {
    logic [6:0]  text_columns;
    logic [11:0] row_pitch;
    logic [3:0]  glyph_width;
    logic [4:0]  glyph_height;
    logic        blink_disable;
    logic        blink_phase;
    logic [6:0]  origin_column;
    logic [4:0]  origin_row;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic                wr;
    logic [FONT_AW-1:0]  faddr;
    logic [7:0]          fdata;
    logic [7:0]          chr;
    logic [ROW_W-1:0]    r;
    logic [HEIGHT_W-1:0] h;
    logic [ADDR_W-1:0]   rowdiff;
    logic [ADDR_W-1:0]   coldiff;
    logic [3:0]          w;
    logic                dbl;
    logic [3:0]          fg;
    logic [3:0]          bg;
    logic                last;
  } tok_t;

  typedef struct packed {
    logic               valid;
    logic               wr;
    logic [FONT_AW-1:0] faddr;
    logic [7:0]         fdata;
    logic [ADDR_W-1:0]  lineidx;
    logic [ADDR_W-1:0]  colterm;
    logic [4:0]         wd;
    logic [3:0]         w;
    logic               dbl;
    logic [3:0]         fg;
    logic [3:0]         bg;
    logic               last;
  } s1_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] lineaddr;
    logic [ADDR_W-1:0] colterm;
    logic [4:0]        wd;
    logic [3:0]        w;
    logic              dbl;
    logic [3:0]        fg;
    logic [3:0]        bg;
    logic              last;
  } s2_t;

endpackage

### hdl/tcir_seq.sv
module tcir_seq import tcir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [55:0] in_data,
  input  logic        en,
  output tok_t        tok
);

  logic                busy;
  logic                wr;
  logic [FONT_AW-1:0]  faddr;
  logic [7:0]          fdata;
  logic [7:0]          chr;
  logic [ROW_W-1:0]    r;
  logic [HEIGHT_W-1:0] h;
  logic [ADDR_W-1:0]   rowdiff;
  logic [ADDR_W-1:0]   coldiff;
  logic [3:0]          w;
  logic                dbl;
  logic [3:0]          fg;
  logic [3:0]          bg;

  logic                h_next;
  logic [HEIGHT_W-1:0] h_cap;
  logic [3:0]          w_cap;
  logic [7:0]          attr;
  logic                blink;
  logic [3:0]          fg_next;
  logic [3:0]          bg_next;
  logic                is_last;

  assign in_ready = !busy;

  always_comb begin
    if (HEIGHT_W'(cfg.glyph_height) > HEIGHT_W'(MAX_GLYPH_ROWS)) begin
      h_cap = HEIGHT_W'(MAX_GLYPH_ROWS);
    end else begin
      h_cap = HEIGHT_W'(cfg.glyph_height);
    end
    if (cfg.glyph_width > 4'(MAX_GLYPH_WIDTH)) begin
      w_cap = 4'(MAX_GLYPH_WIDTH);
    end else if (cfg.glyph_width == 4'd0) begin
      w_cap = 4'd1;
    end else begin
      w_cap = cfg.glyph_width;
    end
    attr  = in_data[47:40];
    blink = attr[7] && !cfg.blink_disable;
    if (blink) begin
      attr[7] = 1'b0;
    end
    bg_next = attr[7:4];
    fg_next = (blink && cfg.blink_phase) ? attr[7:4] : attr[3:0];
    h_next  = (in_op == OP_WRITE) || (in_data[48] && (h_cap != '0));
  end

  assign is_last = (HEIGHT_W'(r) + HEIGHT_W'(1)) == h;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= h_next;
    end else if (busy && en && (wr || is_last)) begin
      busy <= 1'b0;
    end
    if (in_valid && in_ready) begin
      wr      <= (in_op == OP_WRITE);
      faddr   <= in_data[11:0];
      fdata   <= in_data[19:12];
      chr     <= in_data[39:32];
      r       <= '0;
      h       <= h_cap;
      rowdiff <= ADDR_W'(in_data[31:27]) - ADDR_W'(cfg.origin_row);
      coldiff <= ADDR_W'(in_data[26:20]) - ADDR_W'(cfg.origin_column);
      w       <= w_cap;
      dbl     <= (7'(DOUBLE_WIDTH_LIMIT) >= cfg.text_columns);
      fg      <= fg_next;
      bg      <= bg_next;
    end else if (busy && en && !wr) begin
      r <= r + ROW_W'(1);
    end
  end

  always_comb begin
    tok.valid   = busy;
    tok.wr      = wr;
    tok.faddr   = faddr;
    tok.fdata   = fdata;
    tok.chr     = chr;
    tok.r       = r;
    tok.h       = h;
    tok.rowdiff = rowdiff;
    tok.coldiff = coldiff;
    tok.w       = w;
    tok.dbl     = dbl;
    tok.fg      = fg;
    tok.bg      = bg;
    tok.last    = is_last;
  end

endmodule

### hdl/tcir_addr.sv
module tcir_addr import tcir_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  tok_t tok,
  output s1_t  s1
);

  logic [FONT_AW-1:0] glyph_addr;
  logic [4:0]         wd;

  always_comb begin
    glyph_addr = FONT_AW'(tok.chr) * FONT_AW'(tok.h) + FONT_AW'(tok.r);
    wd         = tok.dbl ? {tok.w, 1'b0} : {1'b0, tok.w};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= tok.valid;
    end
    if (en) begin
      s1.wr      <= tok.wr;
      s1.faddr   <= tok.wr ? tok.faddr : glyph_addr;
      s1.fdata   <= tok.fdata;
      s1.lineidx <= tok.rowdiff * ADDR_W'(tok.h) + ADDR_W'(tok.r);
      s1.colterm <= tok.coldiff * ADDR_W'(wd);
      s1.wd      <= wd;
      s1.w       <= tok.w;
      s1.dbl     <= tok.dbl;
      s1.fg      <= tok.fg;
      s1.bg      <= tok.bg;
      s1.last    <= tok.last;
    end
  end

endmodule

### hdl/tcir_font.sv
module tcir_font import tcir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [11:0] row_pitch,
  input  s1_t         s1,
  output s2_t         s2,
  output logic [7:0]  line
);

  logic [7:0] mem [FONT_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (s1.valid && s1.wr) begin
        mem[s1.faddr] <= s1.fdata;
      end
      line <= mem[s1.faddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2.valid <= s1.valid && !s1.wr;
    end
    if (en) begin
      s2.lineaddr <= s1.lineidx * ADDR_W'(row_pitch);
      s2.colterm  <= s1.colterm;
      s2.wd       <= s1.wd;
      s2.w        <= s1.w;
      s2.dbl      <= s1.dbl;
      s2.fg       <= s1.fg;
      s2.bg       <= s1.bg;
      s2.last     <= s1.last;
    end
  end

endmodule

### hdl/tcir_pixel.sv
module tcir_pixel import tcir_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  s2_t               s2,
  input  logic [7:0]        line,
  output logic              out_valid,
  output logic [63:0]       pixels,
  output logic [4:0]        count,
  output logic [ADDR_W-1:0] addr,
  output logic              last
);

  logic [63:0] pix_next;
  logic [3:0]  c;

  always_comb begin
    pix_next = '0;
    for (int p = 0; p < PIX_MAX; p++) begin
      c = s2.dbl ? 4'(p >> 1) : 4'(p);
      if (c < s2.w) begin
        pix_next[4*p +: 4] = line[3'(7 - c)] ? s2.fg : s2.bg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2.valid;
    end
    if (en) begin
      pixels <= pix_next;
      count  <= s2.wd;
      addr   <= s2.lineaddr + s2.colterm;
      last   <= s2.last;
    end
  end

endmodule

### hdl/text_cell_index_renderer_core.sv
// The first result of a rendered cell passes the row sequencer, address, font and pixel
// registers. A new cell is taken only after every glyph row of the last one, or its font
// write, is issued; a skipped cell or one of zero height holds nothing. The row sequencer
// issues one font memory read per cycle while the output is not stalled.
// Reset clears the configuration to its defaults and empties the pipeline; the font
// memory is not cleared and holds undefined data until written.
module text_cell_index_renderer_core import tcir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // font_address, font_data, cell_column, cell_row, char_code, attribute, draw_enable
  input  logic [55:0] s_tdata,
  // operation
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_indices, pixel_count, buffer_address
  output logic [95:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  cfg_t              cfg;
  tok_t              tok;
  s1_t               s1;
  s2_t               s2;
  logic [7:0]        line;
  logic              en;
  logic [63:0]       pixels;
  logic [4:0]        count;
  logic [ADDR_W-1:0] addr;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_columns  <= 7'd80;
      cfg.row_pitch     <= 12'd640;
      cfg.glyph_width   <= 4'd8;
      cfg.glyph_height  <= 5'd14;
      cfg.blink_disable <= 1'b0;
      cfg.blink_phase   <= 1'b0;
      cfg.origin_column <= 7'd0;
      cfg.origin_row    <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEXT_COLUMNS:  cfg.text_columns  <= cfg_data[6:0];
        REG_ROW_PITCH:     cfg.row_pitch     <= cfg_data;
        REG_GLYPH_WIDTH:   cfg.glyph_width   <= cfg_data[3:0];
        REG_GLYPH_HEIGHT:  cfg.glyph_height  <= cfg_data[4:0];
        REG_BLINK_DISABLE: cfg.blink_disable <= cfg_data[0];
        REG_BLINK_PHASE:   cfg.blink_phase   <= cfg_data[0];
        REG_ORIGIN_COLUMN: cfg.origin_column <= cfg_data[6:0];
        REG_ORIGIN_ROW:    cfg.origin_row    <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  tcir_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_data  (s_tdata),
    .en       (en),
    .tok      (tok)
  );

  tcir_addr u_addr (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .tok (tok),
    .s1  (s1)
  );

  tcir_font u_font (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .row_pitch (cfg.row_pitch),
    .s1        (s1),
    .s2        (s2),
    .line      (line)
  );

  tcir_pixel u_pixel (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s2        (s2),
    .line      (line),
    .out_valid (m_tvalid),
    .pixels    (pixels),
    .count     (count),
    .addr      (addr),
    .last      (m_tlast)
  );

  assign m_tdata = {6'd0, addr, count, pixels};

endmodule

### sim/tb_top.sv
module tb_top;
  import tcir_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 7;
  localparam int NUM_DIRECTED = 22;

  typedef struct packed {
    bit [63:0] pix;
    bit [4:0]  cnt;
    bit [20:0] addr;
    bit        last;
  } glyph_row_t;

  typedef struct {
    op_t       op;
    bit [11:0] faddr;
    bit [7:0]  fdata;
    bit [6:0]  col;
    bit [4:0]  row;
    bit [7:0]  chr;
    bit [7:0]  attr;
    bit        draw;
    bit        typed;
    bit [63:0] pix;
    bit [4:0]  cnt;
    bit [20:0] addr;
  } cell_stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  glyph_row_t pending_rows[$];
  logic [7:0] font_copy [FONT_DEPTH];
  bit         font_written [FONT_DEPTH];
  cfg_t       cur_cfg;
  int         errors = 0;
  int         cycles = 0;
  int         send_idle = 33;
  int         recv_idle = 73;
  int         long_hold = 0;

  // Directed cells at the reset configuration: 14 rows, 8 pixels, no doubling, pitch 640.
  cell_stim_t directed_rows [NUM_DIRECTED] = '{
    '{OP_WRITE, 12'd0, 8'hFF, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd1, 8'h00, 7'd127, 5'd31, 8'hFF, 8'hFF, 1'b1, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd2, 8'h80, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd3, 8'h01, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd4, 8'hAA, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd5, 8'h55, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd6, 8'hF0, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd7, 8'h0F, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd8, 8'hC3, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd9, 8'h3C, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd10, 8'h81, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd11, 8'h7E, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd12, 8'h18, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'd13, 8'hE7, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_WRITE, 12'hFFF, 8'h00, 7'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_RENDER, 12'd0, 8'd0, 7'd0, 5'd0, 8'd0, 8'h0F, 1'b1, 1'b1,
      64'h0000_0000_FFFF_FFFF, 5'd8, 21'd0},
    '{OP_RENDER, 12'd0, 8'd0, 7'd1, 5'd0, 8'd0, 8'h8F, 1'b1, 1'b1,
      64'h0000_0000_FFFF_FFFF, 5'd8, 21'd8},
    '{OP_RENDER, 12'd0, 8'd0, 7'd127, 5'd31, 8'd0, 8'h70, 1'b1, 1'b1,
      64'h0000_0000_0000_0000, 5'd8, 21'd278776},
    '{OP_RENDER, 12'd0, 8'd0, 7'd0, 5'd1, 8'd0, 8'hFF, 1'b1, 1'b1,
      64'h0000_0000_FFFF_FFFF, 5'd8, 21'd8960},
    '{OP_RENDER, 12'hFFF, 8'hFF, 7'd5, 5'd5, 8'd0, 8'h00, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_RENDER, 12'd0, 8'd0, 7'd127, 5'd31, 8'hFF, 8'hFF, 1'b0, 1'b0, 64'd0, 5'd0, 21'd0},
    '{OP_RENDER, 12'd0, 8'd0, 7'd3, 5'd2, 8'd0, 8'h12, 1'b1, 1'b0, 64'd0, 5'd0, 21'd0}
  };

  cfg_t phase_cfgs [NUM_PHASES] = '{
    '{7'd40, 12'd4095, 4'd15, 5'd31, 1'b0, 1'b1, 7'd127, 5'd31},
    '{7'd0, 12'd0, 4'd0, 5'd3, 1'b1, 1'b1, 7'd0, 5'd0},
    '{7'd127, 12'd1, 4'd1, 5'd1, 1'b0, 1'b0, 7'd64, 5'd16},
    '{7'd41, 12'd640, 4'd5, 5'd16, 1'b1, 1'b0, 7'd0, 5'd0},
    '{7'd80, 12'd2000, 4'd8, 5'd0, 1'b0, 1'b1, 7'd9, 5'd2},
    '{7'd0, 12'd0, 4'd0, 5'd0, 1'b0, 1'b0, 7'd0, 5'd0},
    '{7'd20, 12'd320, 4'd8, 5'd8, 1'b0, 1'b1, 7'd2, 5'd1}
  };
  int phase_items [NUM_PHASES] = '{15, 15, 18, 15, 10, 15, 15};

  text_cell_index_renderer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit [55:0] pack_cell(input bit [11:0] faddr, input bit [7:0] fdata,
                                          input bit [6:0] col, input bit [4:0] row,
                                          input bit [7:0] chr, input bit [7:0] attr,
                                          input bit draw);
    return {7'd0, draw, attr, chr, row, col, fdata, faddr};
  endfunction

  function automatic int glyph_rows(input cfg_t c);
    return (c.glyph_height > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS : int'(c.glyph_height);
  endfunction

  task automatic predict_glyph_rows(input op_t op, input bit [55:0] d, output int n);
    bit [11:0]  faddr;
    bit [7:0]   fdata;
    bit [6:0]   col;
    bit [4:0]   row;
    bit [7:0]   chr;
    bit [7:0]   attr;
    bit         draw;
    bit [7:0]   line;
    bit [3:0]   fg;
    bit [3:0]   bg;
    bit [3:0]   colour;
    int         w;
    int         h;
    int         dbl;
    int         p;
    longint     base;
    glyph_row_t e;
    {draw, attr, chr, row, col, fdata, faddr} = d[48:0];
    n = 0;
    if (op == OP_WRITE) begin
      font_copy[faddr] = fdata;
      font_written[faddr] = 1'b1;
      return;
    end
    if (!draw) begin
      return;
    end
    w = (cur_cfg.glyph_width > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH :
        ((cur_cfg.glyph_width == 0) ? 1 : int'(cur_cfg.glyph_width));
    h = glyph_rows(cur_cfg);
    dbl = (cur_cfg.text_columns <= DOUBLE_WIDTH_LIMIT) ? 2 : 1;
    if (attr[7] && !cur_cfg.blink_disable) begin
      attr[7] = 1'b0;
      if (cur_cfg.blink_phase) begin
        attr[3:0] = attr[7:4];
      end
    end
    bg = attr[7:4];
    fg = attr[3:0];
    for (int r = 0; r < h; r++) begin
      line = font_copy[(int'(chr) * h + r) % FONT_DEPTH];
      e = '0;
      p = 0;
      for (int c = 0; c < w; c++) begin
        colour = line[7 - c] ? fg : bg;
        for (int k = 0; k < dbl; k++) begin
          e.pix[4 * p +: 4] = colour;
          p++;
        end
      end
      base = ((longint'(row) - longint'(cur_cfg.origin_row)) * h + r)
             * longint'(cur_cfg.row_pitch)
           + (longint'(col) - longint'(cur_cfg.origin_column)) * w * dbl;
      e.cnt  = 5'(w * dbl);
      e.addr = base[20:0];
      e.last = (r == h - 1);
      pending_rows.push_back(e);
      n++;
    end
  endtask

  task automatic send_cell(input op_t op, input bit [55:0] d, output int n);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    predict_glyph_rows(op, d, n);
  endtask

  task automatic drain_rows();
    s_tvalid <= 1'b0;
    while (pending_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    logic [2:0]  idx [8];
    logic [11:0] val [8];
    idx = '{REG_TEXT_COLUMNS, REG_ROW_PITCH, REG_GLYPH_WIDTH, REG_GLYPH_HEIGHT,
            REG_BLINK_DISABLE, REG_BLINK_PHASE, REG_ORIGIN_COLUMN, REG_ORIGIN_ROW};
    val = '{12'(c.text_columns), c.row_pitch, 12'(c.glyph_width), 12'(c.glyph_height),
            12'(c.blink_disable), 12'(c.blink_phase), 12'(c.origin_column),
            12'(c.origin_row)};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic bit [7:0] font_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic render_phase(input int n_items, input bit pause_mid);
    int       sent;
    int       n;
    int       h;
    int       pick;
    bit [7:0] chr;
    bit [11:0] a;
    sent = 0;
    chr = 8'($urandom_range(0, 255));
    h = glyph_rows(cur_cfg);
    while (sent < n_items) begin
      if (pause_mid && sent >= n_items / 2) begin
        pause_mid = 1'b0;
        drain_rows();
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_cell(OP_WRITE, pack_cell(12'($urandom_range(0, 4095)), font_byte(),
                  7'($urandom), 5'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)), n);
        sent++;
      end else if (pick < 18) begin
        send_cell(OP_RENDER, pack_cell(12'($urandom), 8'($urandom), 7'($urandom),
                  5'($urandom), 8'($urandom), 8'($urandom), 1'b0), n);
        sent++;
      end else begin
        if ($urandom_range(0, 99) < 40) begin
          chr = 8'($urandom_range(0, 255));
        end
        // A glyph is rendered only once every row it reads has been loaded.
        for (int r = 0; r < h; r++) begin
          a = 12'((int'(chr) * h + r) % FONT_DEPTH);
          if (!font_written[a] || $urandom_range(0, 99) < 15) begin
            send_cell(OP_WRITE, pack_cell(a, font_byte(), 7'($urandom), 5'($urandom),
                      8'($urandom), 8'($urandom), 1'($urandom)), n);
            sent++;
          end
        end
        repeat ($urandom_range(1, 3)) begin
          send_cell(OP_RENDER, pack_cell(12'($urandom), 8'($urandom),
                    7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)), chr,
                    8'($urandom_range(0, 255)), 1'b1), n);
          sent++;
        end
      end
    end
  endtask

  initial begin
    glyph_row_t e;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_rows.size() == 0) begin
          $error("unexpected result transfer: pixel_indices %h buffer_address %h",
                 m_tdata[63:0], m_tdata[89:69]);
          errors++;
        end else begin
          e = pending_rows.pop_front();
          if (m_tdata[63:0] !== e.pix) begin
            $error("pixel_indices: expected %h, got %h", e.pix, m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[68:64] !== e.cnt) begin
            $error("pixel_count: expected %0d, got %0d", e.cnt, m_tdata[68:64]);
            errors++;
          end
          if (m_tdata[89:69] !== e.addr) begin
            $error("buffer_address: expected %h, got %h", e.addr, m_tdata[89:69]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("last_row: expected %b, got %b", e.last, m_tlast);
            errors++;
          end
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int         n;
    glyph_row_t e;
    cfg_t       c;
    cur_cfg = '{7'd80, 12'd640, 4'd8, 5'd14, 1'b0, 1'b0, 7'd0, 5'd0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_cell(directed_rows[i].op,
                pack_cell(directed_rows[i].faddr, directed_rows[i].fdata, directed_rows[i].col,
                          directed_rows[i].row, directed_rows[i].chr, directed_rows[i].attr,
                          directed_rows[i].draw), n);
      if (directed_rows[i].typed && n > 0) begin
        e = pending_rows[pending_rows.size() - n];
        e.pix  = directed_rows[i].pix;
        e.cnt  = directed_rows[i].cnt;
        e.addr = directed_rows[i].addr;
        pending_rows[pending_rows.size() - n] = e;
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_rows();
      if (ph == 2) begin
        send_idle = 73;
        recv_idle = 33;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      c = phase_cfgs[ph];
      if (ph == 5) begin
        c = '{7'($urandom), 12'($urandom), 4'($urandom_range(1, 8)), 5'($urandom_range(1, 16)),
              1'($urandom), 1'($urandom), 7'($urandom), 5'($urandom)};
      end
      write_config(c);
      // The receiver stalls long enough for the pipeline to back up onto the input.
      if (ph == 3) begin
        long_hold = 300;
      end
      render_phase(phase_items[ph], ph == 2);
    end

    drain_rows();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/tcir_pkg.sv
hdl/tcir_seq.sv
hdl/tcir_addr.sv
hdl/tcir_font.sv
hdl/tcir_pixel.sv
hdl/text_cell_index_renderer_core.sv
sim/tb_top.sv
